>>> rtl/core/bfa_pkg.sv
// Shared constants and control types of the bitmap frame allocator.
package bfa_pkg;

  localparam int NUM_FRAMES_DEF = 32768;
  localparam int FRAME_BYTES    = 4096;
  localparam int PAGE_SHIFT     = $clog2(FRAME_BYTES);
  localparam int ADDR_W         = 27;
  localparam int AFN_W          = ADDR_W - PAGE_SHIFT;
  localparam int CFG_W          = 13;
  localparam int COUNT_W        = 16;
  localparam int ROW_BYTES      = 8;
  localparam int ROW_BITS       = ROW_BYTES * 8;
  localparam int BIT_SEL_W      = $clog2(ROW_BITS);

  localparam logic [CFG_W-1:0]   CFG_RESET = 13'd4096;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [7:0]         BYTE_FULL = 8'hFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic init_wr;
    logic take;
    logic scan;
    logic free_upd;
    logic load_out;
  } bfa_cmd_t;

  typedef struct packed {
    logic init_last;
    logic req_free;
    logic hit;
    logic scan_end;
  } bfa_stat_t;

endpackage

>>> rtl/core/bfa_chan_if.sv
// Channel interfaces of the bitmap frame allocator: request, result and configuration.
interface bfa_in_if import bfa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, cmd, free_addr, input ready);
  modport sink   (input valid, cmd, free_addr, output ready);
endinterface

interface bfa_out_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  page_addr;
  logic               ok;
  logic [COUNT_W-1:0] free_count;

  modport source (output valid, page_addr, ok, free_count, input ready);
  modport sink   (input valid, page_addr, ok, free_count, output ready);
endinterface

interface bfa_cfg_if import bfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> rtl/core/bfa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/bfa_dp.sv
// Datapath: bitmap memory, row scan, free-bit search, free counter and result registers.
module bfa_dp import bfa_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bfa_cmd_t           cmd,
  output bfa_stat_t          stat,
  input  logic               in_cmd,
  input  logic [ADDR_W-1:0]  in_free_addr,
  input  logic               cfg_valid,
  input  logic [CFG_W-1:0]   cfg_data,
  output logic [ADDR_W-1:0]  out_page_addr,
  output logic               out_ok,
  output logic [COUNT_W-1:0] out_free_count
);

  localparam int MAP_BYTES = NUM_FRAMES / 8;
  localparam int DEPTH     = (MAP_BYTES + ROW_BYTES - 1) / ROW_BYTES;
  localparam int ROW_AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_W     = ($clog2(MAP_BYTES + 1) > CFG_W) ? $clog2(MAP_BYTES + 1) : CFG_W;
  localparam int CMP_W     = (ROW_AW + 3 > LIM_W) ? ROW_AW + 3 : LIM_W;
  localparam int FX_W      = (ROW_AW + BIT_SEL_W > AFN_W) ? ROW_AW + BIT_SEL_W : AFN_W;
  localparam int LIM_RESET = (int'(CFG_RESET) < MAP_BYTES) ? int'(CFG_RESET) : MAP_BYTES;

  logic [ROW_AW-1:0]   row_r, row_nxt;
  logic [ROW_AW-1:0]   data_row_r;
  logic [LIM_W-1:0]    lim_r, lim_nxt;
  logic [ADDR_W-1:0]   addr_r;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0]   res_addr_r, res_addr_nxt;
  logic                res_ok_r, res_ok_nxt;
  logic [ADDR_W-1:0]   out_page_addr_r;
  logic                out_ok_r;
  logic [COUNT_W-1:0]  out_free_count_r;

  logic [ROW_AW-1:0]   rd_addr;
  logic [ROW_AW-1:0]   wr_addr;
  logic [ROW_BITS-1:0] wr_data;
  logic                wr_en;
  logic [ROW_BITS-1:0] rdata;

  logic [ROW_BITS-1:0] avail;
  logic [7:0]          byte_any;
  logic [2:0]          sel_k;
  logic [2:0]          sel_b;
  logic [7:0]          sel_byte;
  logic                hit;
  logic [CMP_W:0]      next_byte;
  logic                scan_end;
  logic [FX_W-1:0]     fx;
  logic [ADDR_W-1:0]   hit_addr;

  logic [BIT_SEL_W-1:0] fr_bit;
  logic [AFN_W-4:0]     fr_byte;
  logic                 fr_in_range;
  logic                 fr_set;

  bfa_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    for (int k = 0; k < ROW_BYTES; k++) begin
      logic [CMP_W-1:0] bidx;
      bidx = CMP_W'({data_row_r, 3'(k)});
      avail[k*8 +: 8] = ~rdata[k*8 +: 8] & {8{bidx < CMP_W'(lim_r)}};
      byte_any[k]     = |avail[k*8 +: 8];
    end
    sel_k = '0;
    for (int k = ROW_BYTES - 1; k >= 0; k--) begin
      if (byte_any[k]) begin
        sel_k = 3'(k);
      end
    end
    sel_byte = avail[{sel_k, 3'b000} +: 8];
    sel_b = '0;
    for (int b = 7; b >= 0; b--) begin
      if (sel_byte[b]) begin
        sel_b = 3'(b);
      end
    end
  end

  assign hit       = |byte_any;
  assign next_byte = (CMP_W+1)'({data_row_r, 3'b111}) + (CMP_W+1)'(1);
  assign scan_end  = next_byte >= (CMP_W+1)'(lim_r);
  assign fx        = FX_W'({data_row_r, sel_k, sel_b});
  assign hit_addr  = {fx[AFN_W-1:0], {PAGE_SHIFT{1'b0}}};

  assign fr_bit      = addr_r[PAGE_SHIFT +: BIT_SEL_W];
  assign fr_byte     = addr_r[ADDR_W-1:PAGE_SHIFT+3];
  assign fr_in_range = CMP_W'(fr_byte) < CMP_W'(lim_r);
  assign fr_set      = rdata[fr_bit];

  always_comb begin
    rd_addr = row_r;
    row_nxt = row_r;
    if (cmd.take) begin
      if (in_cmd == CMD_FREE) begin
        rd_addr = ROW_AW'(in_free_addr >> (PAGE_SHIFT + BIT_SEL_W));
      end else begin
        rd_addr = '0;
      end
      row_nxt = ROW_AW'(1);
    end else if (cmd.scan || cmd.init_wr) begin
      row_nxt = row_r + ROW_AW'(1);
    end
  end

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = data_row_r;
    wr_data      = rdata;
    count_nxt    = count_r;
    res_addr_nxt = res_addr_r;
    res_ok_nxt   = res_ok_r;
    if (cmd.init_wr) begin
      wr_en   = 1'b1;
      wr_addr = row_r;
      wr_data = {ROW_BYTES{BYTE_FULL}};
    end else if (cmd.scan) begin
      if (hit) begin
        wr_en        = 1'b1;
        wr_data      = rdata | (ROW_BITS'(1) << {sel_k, sel_b});
        res_addr_nxt = hit_addr;
        res_ok_nxt   = 1'b1;
        if (count_r != '0) begin
          count_nxt = count_r - COUNT_W'(1);
        end
      end else if (scan_end) begin
        res_addr_nxt = '0;
        res_ok_nxt   = 1'b0;
      end
    end else if (cmd.free_upd) begin
      res_addr_nxt = '0;
      res_ok_nxt   = fr_in_range;
      if (fr_in_range && fr_set) begin
        wr_en   = 1'b1;
        wr_data = rdata & ~(ROW_BITS'(1) << fr_bit);
        if (count_r != COUNT_MAX) begin
          count_nxt = count_r + COUNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    lim_nxt = lim_r;
    if (cfg_valid) begin
      lim_nxt = (LIM_W'(cfg_data) < LIM_W'(MAP_BYTES)) ? LIM_W'(cfg_data) : LIM_W'(MAP_BYTES);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      lim_r   <= LIM_W'(LIM_RESET);
      count_r <= '0;
    end else begin
      row_r   <= row_nxt;
      lim_r   <= lim_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_row_r <= rd_addr;
    res_addr_r <= res_addr_nxt;
    res_ok_r   <= res_ok_nxt;
    if (cmd.take) begin
      addr_r <= in_free_addr;
    end
    if (cmd.load_out) begin
      out_page_addr_r  <= res_addr_r;
      out_ok_r         <= res_ok_r;
      out_free_count_r <= count_r;
    end
  end

  assign stat.init_last = (row_r == ROW_AW'(DEPTH - 1));
  assign stat.req_free  = (in_cmd == CMD_FREE);
  assign stat.hit       = hit;
  assign stat.scan_end  = scan_end;

  assign out_page_addr  = out_page_addr_r;
  assign out_ok         = out_ok_r;
  assign out_free_count = out_free_count_r;

endmodule

>>> rtl/core/bfa_ctrl.sv
// Controller: clearing pass, command dispatch, row scan sequencing and output handshake.
module bfa_ctrl import bfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bfa_stat_t stat,
  output bfa_cmd_t  cmd
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FREE   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = stat.req_free ? ST_FREE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.scan_end) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_FREE: begin
        cmd.free_upd = 1'b1;
        state_nxt    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_init_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_INIT |=> state_r != ST_INIT)
    else $error("clearing pass re-entered");

  a_take_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == ST_SCAN || state_r == ST_FREE))
    else $error("accepted beat not dispatched");

  a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && (stat.hit || stat.scan_end) |=> state_r == ST_RESULT)
    else $error("scan did not stop on hit or end");

  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result beat raised outside result state");
`endif

endmodule

>>> rtl/core/bitmap_frame_allocator.sv
// Top level of the bitmap page frame allocator, first fit.
//
// Channels: in_ch carries one command beat (cmd 0 allocate, cmd 1 free the
// frame at free_addr), out_ch returns exactly one result beat per command
// (page_addr, ok, free_count), cfg_ch writes the number of bitmap bytes in
// use and is always ready; write it only while no command is in flight.
// The bitmap sits in one RAM of 64-bit rows, (NUM_FRAMES/8)/8 rows deep, rounded up.
// Sequence: a free reads its RAM row, then updates the row, the count and
// the result. An allocate scans from row 0 and stops at the row holding the
// first free frame or, when no frame is free, at the last row within the n
// bytes in use (n capped at NUM_FRAMES/8), row 0 when n is 0. The row scan
// reads one RAM row per cycle and sets the rate. One command is in work at
// a time; the next is accepted once the result sits in the output register.
// Reset: the free count clears, the register returns to 4096 (capped at
// NUM_FRAMES/8) and a clearing pass marks every frame used, one row per
// cycle over all RAM rows (512 at the default size); in_ch.ready stays low meanwhile.
// Stall: a result beat holds in the output register; the next command is
// completed and waits until that beat is taken.
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  bfa_in_if.sink   in_ch,
  bfa_out_if.source out_ch,
  bfa_cfg_if.sink  cfg_ch
);

  bfa_cmd_t  cmd;
  bfa_stat_t stat;

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfa_dp #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_cmd         (in_ch.cmd),
    .in_free_addr   (in_ch.free_addr),
    .cfg_valid      (cfg_ch.valid),
    .cfg_data       (cfg_ch.data),
    .out_page_addr  (out_ch.page_addr),
    .out_ok         (out_ch.ok),
    .out_free_count (out_ch.free_count)
  );

  assign cfg_ch.ready = 1'b1;

endmodule

>>> tb/bitmap_frame_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the bitmap frame allocator: random and directed commands vs. a predicted bitmap.
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  localparam int MAP_BYTES    = NUM_FRAMES_DEF / 8;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 100;
  localparam int NEAR_FRAMES  = 2048;

  typedef struct packed {
    logic [ADDR_W-1:0]  page_addr;
    logic               ok;
    logic [COUNT_W-1:0] free_count;
  } alloc_reply_t;

  typedef enum int {SINK_ALWAYS, SINK_HALF, SINK_SPARSE} sink_mode_t;

  class frame_map_ledger;
    bit [7:0]         usage_map [MAP_BYTES];
    bit [COUNT_W-1:0] free_cnt;
    bit [CFG_W-1:0]   bytes_in_use;
    alloc_reply_t     awaited_replies [$];
    int               errors;

    function new();
      foreach (usage_map[i]) usage_map[i] = BYTE_FULL;
      free_cnt     = '0;
      bytes_in_use = CFG_RESET;
      errors       = 0;
    endfunction

    function void set_bytes_in_use(bit [CFG_W-1:0] value);
      bytes_in_use = value;
    endfunction

    function void note_request(logic cmd, logic [ADDR_W-1:0] addr);
      alloc_reply_t reply;
      int           limit;
      int           row;
      int           frame;
      bit           found;
      reply = '0;
      found = 1'b0;
      limit = (int'(bytes_in_use) < MAP_BYTES) ? int'(bytes_in_use) : MAP_BYTES;
      if (cmd == CMD_ALLOC) begin
        for (row = 0; row < limit && !found; row++) begin
          if (usage_map[row] != BYTE_FULL) begin
            for (int b = 0; b < 8 && !found; b++) begin
              if (!usage_map[row][b]) begin
                usage_map[row][b] = 1'b1;
                if (free_cnt > 0) free_cnt--;
                frame           = row * 8 + b;
                reply.page_addr = ADDR_W'(frame) << PAGE_SHIFT;
                reply.ok        = 1'b1;
                found           = 1'b1;
              end
            end
          end
        end
      end else begin
        frame = int'(addr >> PAGE_SHIFT);
        row   = frame / 8;
        if (row < limit) begin
          if (usage_map[row][frame % 8]) begin
            usage_map[row][frame % 8] = 1'b0;
            if (free_cnt < COUNT_MAX) free_cnt++;
          end
          reply.ok = 1'b1;
        end
      end
      reply.free_count = free_cnt;
      awaited_replies.push_back(reply);
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [ADDR_W-1:0] page_addr, logic ok, logic [COUNT_W-1:0] free_count);
      alloc_reply_t want;
      if (awaited_replies.size() == 0) begin
        report($sformatf("unexpected reply beat: addr %0h ok %0b count %0d",
                         page_addr, ok, free_count));
      end else begin
        want = awaited_replies.pop_front();
        if (page_addr !== want.page_addr)
          report($sformatf("page_addr got %0h, want %0h", page_addr, want.page_addr));
        if (ok !== want.ok)
          report($sformatf("ok got %0b, want %0b", ok, want.ok));
        if (free_count !== want.free_count)
          report($sformatf("free_count got %0d, want %0d", free_count, want.free_count));
      end
    endtask
  endclass

  logic            clk;
  logic            rst_n;
  frame_map_ledger ledger;
  int unsigned     burst_left;
  int unsigned     stall_cycles;
  logic            hold_request;

  bfa_in_if  in_ch ();
  bfa_out_if out_ch ();
  bfa_cfg_if cfg_ch ();

  bitmap_frame_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic write_bytes_in_use(input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_request(input logic cmd, input logic [ADDR_W-1:0] addr);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.free_addr <= addr;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (ledger.awaited_replies.size() != 0);
  endtask

  task automatic run_random_phase(input logic [CFG_W-1:0] bytes_setting, input bit with_hold);
    int unsigned full_span;
    int unsigned near_span;
    int unsigned pick;
    int unsigned frame;
    settle();
    write_bytes_in_use(bytes_setting);
    full_span = ((bytes_setting < MAP_BYTES) ? bytes_setting : MAP_BYTES) * 8;
    near_span = (full_span > NEAR_FRAMES) ? NEAR_FRAMES : full_span;
    if (with_hold) hold_request = 1'b1;
    repeat (PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_request(CMD_ALLOC, ADDR_W'($urandom));
      end else if (pick < 90) begin
        frame = (pick < 84) ? $urandom_range(0, near_span - 1) : $urandom_range(0, full_span - 1);
        send_request(CMD_FREE, {AFN_W'(frame), PAGE_SHIFT'($urandom)});
      end else begin
        send_request(CMD_FREE, ADDR_W'($urandom));
      end
    end
  endtask

  initial begin
    ledger          = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_ALLOC;
    in_ch.free_addr = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.data     = CFG_RESET;
    hold_request    = 1'b0;
    burst_left      = 0;
    stall_cycles    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_bytes_in_use(CFG_RESET);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_FREE,  27'h0000ABC);
    send_request(CMD_FREE,  27'h0000000);
    send_request(CMD_FREE,  27'h7FFFFFF);
    send_request(CMD_ALLOC, 27'h7FFFFFF);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_FREE,  27'h0001000);
    send_request(CMD_FREE,  27'h0008FFF);

    settle();
    write_bytes_in_use(13'd0);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_FREE,  27'h0000000);
    send_request(CMD_FREE,  27'h7FFFFFF);

    settle();
    write_bytes_in_use(13'd1);
    send_request(CMD_FREE,  27'h0008000);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_FREE,  27'h0007123);
    send_request(CMD_ALLOC, 27'h0000000);

    settle();
    write_bytes_in_use(13'd8191);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_FREE,  27'h4000000);
    send_request(CMD_FREE,  27'h7FFF000);
    send_request(CMD_ALLOC, 27'h0000000);
    send_request(CMD_ALLOC, 27'h0000000);

    run_random_phase(13'd2, 1'b0);
    run_random_phase(13'd16, 1'b1);
    run_random_phase(13'd4096, 1'b0);
    run_random_phase(13'd64, 1'b0);
    run_random_phase(13'd1, 1'b0);
    run_random_phase(CFG_W'($urandom_range(3, 200)), 1'b0);
    run_random_phase(13'd8, 1'b0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    sink_mode_t  mode;
    int unsigned run_left;
    int unsigned hold_left;
    out_ch.ready = 1'b0;
    mode         = SINK_ALWAYS;
    run_left     = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(4, 60);
          mode     = sink_mode_t'($urandom_range(0, 2));
        end
        run_left--;
        case (mode)
          SINK_ALWAYS: out_ch.ready <= 1'b1;
          SINK_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
          default:     out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) ledger.set_bytes_in_use(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) ledger.note_request(in_ch.cmd, in_ch.free_addr);
      if (out_ch.valid && out_ch.ready)
        ledger.check_result(out_ch.page_addr, out_ch.ok, out_ch.free_count);
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

>>> filelist.f
rtl/core/bfa_pkg.sv
rtl/core/bfa_chan_if.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_dp.sv
rtl/core/bfa_ctrl.sv
rtl/core/bitmap_frame_allocator.sv
tb/bitmap_frame_allocator_tb.sv
